### design/decaying_sine_click_generator_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decaying sine click generator
// Immediate-consequence and next-cycle property checks; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef DECAYING_SINE_CLICK_GENERATOR_UNIT_DEFINES_SVH
`define DECAYING_SINE_CLICK_GENERATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DSCG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dscg: same-cycle check failed");
`define DSCG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dscg: next-cycle check failed");
`else
`define DSCG_ASSERT_SAME(label, clk, rst, ante, cons)
`define DSCG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/dscg_pkg.sv
// ----------------------------------------------------------------------------
// dscg_pkg
// Shared types and constants of the decaying sine click generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dscg_pkg;

   localparam int ENV_BITS      = 25;
   localparam int DECAY_BITS    = 24;
   localparam int LEVEL_BITS    = 17;
   localparam int GAIN_BITS     = 18;
   localparam int STEP_BITS     = 32;
   localparam int SINE_BITS     = 15;
   localparam int MAG_BITS      = 19;  // worst case of |sin|*env*level*gain
   localparam int MUL_BITS      = 25;
   localparam int PROD_BITS     = 2 * MUL_BITS;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;

   localparam logic [ENV_BITS-1:0] ENV_ONE       = 25'h100_0000;
   localparam logic [ENV_BITS-1:0] ENV_THRESHOLD = 25'd1678;

   localparam logic [STEP_BITS-1:0]  RST_STEP_NORMAL  = 32'd107374182;
   localparam logic [STEP_BITS-1:0]  RST_STEP_ACCENT  = 32'd161061273;
   localparam logic [DECAY_BITS-1:0] RST_DECAY_NORMAL = 24'd16764742;
   localparam logic [DECAY_BITS-1:0] RST_DECAY_ACCENT = 24'd16768480;
   localparam logic [LEVEL_BITS-1:0] RST_LEVEL_NORMAL = 17'd22282;
   localparam logic [LEVEL_BITS-1:0] RST_LEVEL_ACCENT = 17'd36045;
   localparam logic [GAIN_BITS-1:0]  RST_GAIN         = 18'd65536;

   typedef enum logic [2:0] {
      REG_CLICK_ENABLE = 3'd0,
      REG_STEP_NORMAL  = 3'd1,
      REG_STEP_ACCENT  = 3'd2,
      REG_DECAY_NORMAL = 3'd3,
      REG_DECAY_ACCENT = 3'd4,
      REG_LEVEL_NORMAL = 3'd5,
      REG_LEVEL_ACCENT = 3'd6,
      REG_OUTPUT_GAIN  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                  click_enable;
      logic [STEP_BITS-1:0]  phase_step_normal;
      logic [STEP_BITS-1:0]  phase_step_accent;
      logic [DECAY_BITS-1:0] decay_normal;
      logic [DECAY_BITS-1:0] decay_accent;
      logic [LEVEL_BITS-1:0] level_normal;
      logic [LEVEL_BITS-1:0] level_accent;
      logic [GAIN_BITS-1:0]  output_gain;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_ENV,
      ST_MUL_LEVEL,
      ST_MUL_GAIN,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ENV,
      OP_LEVEL,
      OP_GAIN,
      OP_DECAY
   } mul_op_type;

   typedef struct packed {
      logic       load;    // input transfer: capture sample, trigger, table read
      mul_op_type op;      // what the shared multiplier works on
      logic       finish;  // write result register, advance phase and envelope
   } cmd_type;

endpackage

### design/dscg_regs.sv
// ----------------------------------------------------------------------------
// dscg_regs
// APB-style configuration registers of the click generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dscg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dscg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [dscg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [dscg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output dscg_pkg::cfg_type                   cfg
);
   import dscg_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_CLICK_ENABLE: cfg_in.click_enable      = csr_pwdata[0];
            REG_STEP_NORMAL:  cfg_in.phase_step_normal = csr_pwdata[STEP_BITS-1:0];
            REG_STEP_ACCENT:  cfg_in.phase_step_accent = csr_pwdata[STEP_BITS-1:0];
            REG_DECAY_NORMAL: cfg_in.decay_normal      = csr_pwdata[DECAY_BITS-1:0];
            REG_DECAY_ACCENT: cfg_in.decay_accent      = csr_pwdata[DECAY_BITS-1:0];
            REG_LEVEL_NORMAL: cfg_in.level_normal      = csr_pwdata[LEVEL_BITS-1:0];
            REG_LEVEL_ACCENT: cfg_in.level_accent      = csr_pwdata[LEVEL_BITS-1:0];
            REG_OUTPUT_GAIN:  cfg_in.output_gain       = csr_pwdata[GAIN_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_CLICK_ENABLE: csr_prdata = CSR_DATA_BITS'(cfg_ff.click_enable);
         REG_STEP_NORMAL:  csr_prdata = CSR_DATA_BITS'(cfg_ff.phase_step_normal);
         REG_STEP_ACCENT:  csr_prdata = CSR_DATA_BITS'(cfg_ff.phase_step_accent);
         REG_DECAY_NORMAL: csr_prdata = CSR_DATA_BITS'(cfg_ff.decay_normal);
         REG_DECAY_ACCENT: csr_prdata = CSR_DATA_BITS'(cfg_ff.decay_accent);
         REG_LEVEL_NORMAL: csr_prdata = CSR_DATA_BITS'(cfg_ff.level_normal);
         REG_LEVEL_ACCENT: csr_prdata = CSR_DATA_BITS'(cfg_ff.level_accent);
         REG_OUTPUT_GAIN:  csr_prdata = CSR_DATA_BITS'(cfg_ff.output_gain);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.click_enable      <= 1'b1;
         cfg_ff.phase_step_normal <= RST_STEP_NORMAL;
         cfg_ff.phase_step_accent <= RST_STEP_ACCENT;
         cfg_ff.decay_normal      <= RST_DECAY_NORMAL;
         cfg_ff.decay_accent      <= RST_DECAY_ACCENT;
         cfg_ff.level_normal      <= RST_LEVEL_NORMAL;
         cfg_ff.level_accent      <= RST_LEVEL_ACCENT;
         cfg_ff.output_gain       <= RST_GAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/dscg_ctrl.sv
// ----------------------------------------------------------------------------
// dscg_ctrl
// Sequencer: steps the shared multiplier and owns the result handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dscg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dscg_pkg::cmd_type cmd
);
   import dscg_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_MUL_ENV;
         ST_MUL_ENV:   state_in = ST_MUL_LEVEL;
         ST_MUL_LEVEL: state_in = ST_MUL_GAIN;
         ST_MUL_GAIN:  state_in = ST_FINISH;
         ST_FINISH:    if (slot_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd.op     = OP_NONE;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_ready = 1'b1;
         ST_MUL_ENV:   cmd.op = OP_ENV;
         ST_MUL_LEVEL: cmd.op = OP_LEVEL;
         ST_MUL_GAIN:  cmd.op = OP_GAIN;
         ST_FINISH: begin
            cmd.op     = OP_DECAY;
            cmd.finish = slot_free;
         end
         default:      req_ready = 1'b0;
      endcase
      cmd.load = req_valid & req_ready;
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/dscg_dp.sv
// ----------------------------------------------------------------------------
// dscg_dp
// Oscillator state, sine ROM, shared multiplier and saturating mixers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dscg_dp #(
   parameter int SAMPLE_BITS     = 24,
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dscg_pkg::cmd_type             cmd,
   input  dscg_pkg::cfg_type             cfg,
   input  logic                          req_trigger,
   input  logic                          req_accent,
   input  logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  logic signed [SAMPLE_BITS-1:0] req_right_in,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   output logic                          rsp_clipped,
   output logic                          rsp_click_active
);
   import dscg_pkg::*;

   localparam int TAB_N   = 1 << SINE_TABLE_BITS;
   localparam int ADDR_W  = SINE_TABLE_BITS + 1;
   localparam int SHIFT_W = MAG_BITS + SAMPLE_BITS - 16;
   localparam int SUM_W   = SHIFT_W + 2;
   localparam int HI_W    = SUM_W - SAMPLE_BITS + 1;
   localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [SINE_BITS-1:0] rom_type [TAB_N+1];

   // quarter-wave entry: Taylor series to x^11 in Q30, rounded to Q15
   function automatic logic [SINE_BITS-1:0] sine_entry(input int unsigned k);
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] t;
      logic [63:0] s;
      a  = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
      a2 = (a * a) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((a2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((a2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((a2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((a2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((a2 * t) >> 30) / 64'd6;
      s  = (a * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) s = 64'd32767;
      return s[SINE_BITS-1:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type rom;
      for (int k = 0; k <= TAB_N; k++) rom[k] = sine_entry(k);
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // saturate to the sample range; MSB of the result is the clip flag
   function automatic logic [SAMPLE_BITS:0] saturate(input logic signed [SUM_W-1:0] v);
      logic [HI_W-1:0] hi;
      hi = v[SUM_W-1:SAMPLE_BITS-1];
      if ((&hi) || !(|hi)) return {1'b0, v[SAMPLE_BITS-1:0]};
      if (v[SUM_W-1]) return {1'b1, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
      return {1'b1, 1'b0, {(SAMPLE_BITS-1){1'b1}}};
   endfunction

   // oscillator state
   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] step_ff;
   logic [ENV_BITS-1:0]   env_ff;
   logic [DECAY_BITS-1:0] decay_ff;
   logic [LEVEL_BITS-1:0] level_ff;

   // per-sample working registers
   logic signed [SAMPLE_BITS-1:0] left_ff;
   logic signed [SAMPLE_BITS-1:0] right_ff;
   logic [SINE_BITS-1:0]          sine_ff;
   logic                          neg_ff;
   logic                          active_ff;
   logic [MAG_BITS-1:0]           mag_ff;

   logic                          trig_load;
   logic [PHASE_BITS-1:0]         phase_eff;
   logic [SINE_TABLE_BITS-1:0]    tab_idx;
   logic [ADDR_W-1:0]             rom_addr;
   logic [MUL_BITS-1:0]           mul_a;
   logic [MUL_BITS-1:0]           mul_b;
   logic [PROD_BITS-1:0]          prod;
   logic [SHIFT_W-1:0]            click_mag;
   logic signed [SUM_W-1:0]       click_val;
   logic signed [SUM_W-1:0]       sum_left;
   logic signed [SUM_W-1:0]       sum_right;
   logic [SAMPLE_BITS:0]          sat_left;
   logic [SAMPLE_BITS:0]          sat_right;

   assign trig_load = cmd.load & cfg.click_enable & req_trigger;
   assign phase_eff = trig_load ? '0 : phase_ff;
   assign tab_idx   = phase_eff[PHASE_BITS-3 -: SINE_TABLE_BITS];

   // odd quadrants read the table mirrored
   always_comb begin
      if (phase_eff[PHASE_BITS-2]) begin
         rom_addr = ADDR_W'(TAB_N) - {1'b0, tab_idx};
      end else begin
         rom_addr = {1'b0, tab_idx};
      end
   end

   always_comb begin
      case (cmd.op)
         OP_ENV: begin
            mul_a = env_ff;
            mul_b = MUL_BITS'(sine_ff);
         end
         OP_LEVEL: begin
            mul_a = MUL_BITS'(mag_ff);
            mul_b = MUL_BITS'(level_ff);
         end
         OP_GAIN: begin
            mul_a = MUL_BITS'(mag_ff);
            mul_b = MUL_BITS'(cfg.output_gain);
         end
         OP_DECAY: begin
            mul_a = env_ff;
            mul_b = MUL_BITS'(decay_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   end

   assign click_mag = SHIFT_W'(mag_ff) << (SAMPLE_BITS - 16);

   always_comb begin
      if (!active_ff) begin
         click_val = '0;
      end else if (neg_ff) begin
         click_val = -signed'(SUM_W'(click_mag));
      end else begin
         click_val = signed'(SUM_W'(click_mag));
      end
      sum_left  = SUM_W'(left_ff) + click_val;
      sum_right = SUM_W'(right_ff) + click_val;
      sat_left  = saturate(sum_left);
      sat_right = saturate(sum_right);
   end

   // oscillator and envelope state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         step_ff  <= '0;
         env_ff   <= '0;
         decay_ff <= '0;
         level_ff <= '0;
      end else if (trig_load) begin
         phase_ff <= '0;
         env_ff   <= ENV_ONE;
         step_ff  <= req_accent ? cfg.phase_step_accent[PHASE_BITS-1:0]
                                : cfg.phase_step_normal[PHASE_BITS-1:0];
         decay_ff <= req_accent ? cfg.decay_accent : cfg.decay_normal;
         level_ff <= req_accent ? cfg.level_accent : cfg.level_normal;
      end else if (cmd.finish && active_ff) begin
         phase_ff <= phase_ff + step_ff;
         env_ff   <= prod[24 +: ENV_BITS];
      end
   end

   // sample capture, ROM read and magnitude chain
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_ff  <= req_left_in;
         right_ff <= req_right_in;
         sine_ff  <= SINE_ROM[rom_addr];
         neg_ff   <= phase_eff[PHASE_BITS-1];
      end
      case (cmd.op)
         OP_ENV: begin
            mag_ff    <= prod[24 +: MAG_BITS];
            active_ff <= (env_ff >= ENV_THRESHOLD);
         end
         OP_LEVEL: mag_ff <= prod[16 +: MAG_BITS];
         OP_GAIN:  mag_ff <= prod[16 +: MAG_BITS];
         default:  mag_ff <= mag_ff;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_left_out     <= sat_left[SAMPLE_BITS-1:0];
         rsp_right_out    <= sat_right[SAMPLE_BITS-1:0];
         rsp_clipped      <= sat_left[SAMPLE_BITS] | sat_right[SAMPLE_BITS];
         rsp_click_active <= active_ff;
      end
   end

endmodule

### design/decaying_sine_click_generator_unit.sv
// ----------------------------------------------------------------------------
// decaying_sine_click_generator_unit
// Mixes an exponentially decaying sine click into a stereo sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one stereo sample plus trigger and accent flags; rsp_* returns
//   the sample with the click added, saturated, with clipped and click_active.
//   Both channels use valid/ready; a transfer happens when both are high.
//   csr_* is an APB-style port, register i at byte address 4*i, pready tied high.
//   A result is registered in the finish step, after the env, level and gain
//   steps that follow its input transfer. The single 25x25 multiplier is used
//   four times per sample (env, level, gain, decay), and a new input is only
//   taken in the idle step, once the previous sample has been finished.
//   Stall: the finished result sits in the output register; the next input is
//   accepted while it waits. A second result holds in the final step (and the
//   input side stays not ready) until the output register is taken.
//   Reset: registers return to their defaults, the envelope clears to zero so
//   no click sounds until a trigger; the sine ROM is constant and needs no fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decaying_sine_click_generator_unit_defines.svh"

module decaying_sine_click_generator_unit #(
   parameter int SAMPLE_BITS     = 24,
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   // input sample channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_trigger,
   input  logic                                req_accent,
   input  logic signed [SAMPLE_BITS-1:0]       req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]       req_right_in,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]       rsp_right_out,
   output logic                                rsp_clipped,
   output logic                                rsp_click_active,
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dscg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [dscg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [dscg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import dscg_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   // register file: enable, per-accent step/decay/level, output gain
   dscg_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: idle -> env -> level -> gain -> finish
   dscg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // oscillator, envelope, sine ROM, shared multiplier, mixers
   dscg_dp #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg),
      .req_trigger      (req_trigger),
      .req_accent       (req_accent),
      .req_left_in      (req_left_in),
      .req_right_in     (req_right_in),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .rsp_clipped      (rsp_clipped),
      .rsp_click_active (rsp_click_active)
   );

   // once a sample is taken the sequencer is busy for the next cycle
   `DSCG_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)
   // a new result only appears as the sequencer returns to idle
   `DSCG_ASSERT_SAME(a_result_from_busy, clock, reset, $rose(rsp_valid), req_ready && $past(!req_ready))
   // no clip can come from a silent sample
   `DSCG_ASSERT_SAME(a_clip_needs_click, clock, reset, rsp_valid && rsp_clipped, rsp_click_active)

endmodule
